[rtl/core/mscts_pkg.sv]
`default_nettype none

package mscts_pkg;

  // item codes on the mode field
  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_PERIODIC = 3'd1,
    MODE_ONCE     = 3'd2,
    MODE_STOP     = 3'd3,
    MODE_QUERY    = 3'd4
  } mode_t;

  // run kind
  localparam logic KIND_PERIODIC = 1'b0;
  localparam logic KIND_ONCE     = 1'b1;

  // longest periodic interval
  localparam logic [15:0] PERIOD_MS_MAX = 16'd1999;

  // milliseconds per second, width of the fraction sum
  localparam logic [10:0] MS_PER_SEC = 11'd1000;

  // width of a remainder modulo one thousand
  localparam int FRAC_W = 10;

endpackage

`default_nettype wire

[rtl/core/mscts_ms_scale.sv]
`default_nettype none

// ms * 2^TICK_SHIFT / 1000 as quotient and remainder, by reciprocal multiply
module mscts_ms_scale #(
  parameter int TICK_SHIFT = 15
) (
  input  wire logic [15:0]                     ms,
  output logic      [TICK_SHIFT+6:0]           quot,
  output logic      [mscts_pkg::FRAC_W-1:0]    frac
);

  // 1000 = 8 * 125: divide ms << (TICK_SHIFT - 3) by 125
  localparam int SH    = TICK_SHIFT - 3;
  localparam int K     = 23;
  localparam int MW    = TICK_SHIFT + 14;
  localparam int PW    = MW + 16;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << (SH + K)) + 64'd124) / 64'd125);

  logic [PW-1:0]    prod;
  logic [SH+15:0]   shifted;
  logic [6:0]       rem7;

  assign prod    = PW'(ms) * PW'(RECIP);
  assign quot    = prod[PW-1:K];
  assign shifted = (SH + 16)'(ms) << SH;
  // remainder below 125 so 7 bits of the difference are exact
  assign rem7    = shifted[6:0] - (quot[6:0] * 7'd125);
  assign frac    = {rem7, 3'b000};

endmodule

`default_nettype wire

[rtl/core/ms_compare_timer_scheduler_core.sv]
`default_nettype none

// channel  | handshake          | word
// ---------+--------------------+-------------------------------------
// input    | in_valid, in_stall | mode[2:0], interval_ms[15:0]
// output   | out_valid,out_stall| fired, fired_ms[15:0], passed_ms[15:0]
//
// one word per cycle in and out while neither side stalls; a taken word waits in the
// staging register, is executed from there and offered from the result register
// the scaling multiplier sits in front of the staging register; execute adds and compares
// rst is synchronous and clears the timer state and both stage valids
// out_stall holds the result register; the staging register keeps taking words while
// the result register can move, so in_stall rises only when both are full
module ms_compare_timer_scheduler_core #(
  parameter int COUNTER_BITS = 16,
  parameter int TICK_SHIFT   = 15
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [15:0] interval_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             fired,
  output logic      [15:0] fired_ms,
  output logic      [15:0] passed_ms
);

  localparam int CB = COUNTER_BITS;
  localparam int RW = TICK_SHIFT + 7;           // one-shot tick total
  localparam int AW = (CB > RW + 1) ? CB : RW + 1;
  localparam int FW = mscts_pkg::FRAC_W;
  localparam int SW = RW + 10;                  // ticks times 1000
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam logic [AW-1:0] CAP     = (AW'(1) << CB) - AW'(1);

  // front end: clamp and scale the interval
  logic [15:0]   ms_eff;
  logic [RW-1:0] scale_quot;
  logic [FW-1:0] scale_frac;

  assign ms_eff = (mode == mscts_pkg::MODE_PERIODIC && interval_ms > mscts_pkg::PERIOD_MS_MAX)
                  ? mscts_pkg::PERIOD_MS_MAX : interval_ms;

  mscts_ms_scale #(
    .TICK_SHIFT (TICK_SHIFT)
  ) u_scale (
    .ms   (ms_eff),
    .quot (scale_quot),
    .frac (scale_frac)
  );

  // staging register
  logic                stage_valid;
  mscts_pkg::mode_t    stage_mode;
  logic [15:0]         stage_ms;
  logic [RW-1:0]       stage_quot;
  logic [FW-1:0]       stage_frac;

  logic exec_fire;
  logic in_take;

  assign exec_fire = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !exec_fire;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (exec_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_mode <= mscts_pkg::mode_t'(mode);
      stage_ms   <= ms_eff;
      stage_quot <= scale_quot;
      stage_frac <= scale_frac;
    end
  end

  // timer state
  logic [CB-1:0] tick_count, tick_count_next;
  logic [CB-1:0] compare_value, compare_value_next;
  logic          armed, armed_next;
  logic          run_kind, run_kind_next;
  logic [15:0]   run_ms, run_ms_next;
  logic [RW-1:0] run_ticks, run_ticks_next;      // periodic: whole ticks per period
  logic [RW-1:0] remaining_or_fraction, remaining_or_fraction_next;
  logic [FW-1:0] period_frac, period_frac_next;           // periodic: milli-tick remainder

  // periodic step with carried fraction
  logic [FW:0]   frac_sum;
  logic          frac_carry;
  logic [FW-1:0] frac_adj;
  logic [AW-1:0] period_step;

  assign frac_sum    = {1'b0, period_frac} + {1'b0, remaining_or_fraction[FW-1:0]};
  assign frac_carry  = frac_sum >= mscts_pkg::MS_PER_SEC;
  assign frac_adj    = frac_carry ? FW'(frac_sum - mscts_pkg::MS_PER_SEC) : frac_sum[FW-1:0];
  assign period_step = AW'(run_ticks) + AW'(frac_carry);

  // one-shot chunks, capped at the counter range
  logic [AW-1:0] cur_chunk;
  logic [RW-1:0] once_total;
  logic [AW-1:0] once_chunk;

  assign cur_chunk  = (AW'(remaining_or_fraction) > CAP) ? CAP : AW'(remaining_or_fraction);
  assign once_total = stage_quot + RW'(stage_frac != '0);
  assign once_chunk = (AW'(once_total) > CAP) ? CAP : AW'(once_total);

  // elapsed one-shot time
  logic [CB-1:0]   left_raw;
  logic [CB-1:0]   left_adj;
  logic [AW:0]     rem_sum;
  logic [RW-1:0]   rem_clamp;
  logic [RW-1:0]   done_ticks;
  logic [SW-1:0]   done_scaled;
  logic [SW-TICK_SHIFT-1:0] el_full;
  logic [15:0]     el_clamp;
  logic [15:0]     query_el;

  assign left_raw    = compare_value - tick_count;
  assign left_adj    = (left_raw == CNT_MAX) ? '0 : left_raw;
  assign rem_sum     = (AW + 1)'(remaining_or_fraction) + (AW + 1)'(left_adj);
  assign rem_clamp   = (rem_sum > (AW + 1)'(run_ticks)) ? run_ticks : rem_sum[RW-1:0];
  assign done_ticks  = run_ticks - rem_clamp;
  // times 1000 as 1024 - 16 - 8
  assign done_scaled = (SW'(done_ticks) << 10) - (SW'(done_ticks) << 4) - (SW'(done_ticks) << 3);
  assign el_full     = done_scaled[SW-1:TICK_SHIFT];
  assign el_clamp    = (el_full > (SW - TICK_SHIFT)'(run_ms)) ? run_ms : el_full[15:0];
  assign query_el    = (run_kind == mscts_pkg::KIND_ONCE && run_ticks != '0) ? el_clamp : '0;

  // execute
  logic [CB-1:0] tick_inc;
  logic          res_fired;
  logic [15:0]   res_fired_ms;
  logic [15:0]   res_elapsed;

  assign tick_inc = tick_count + CB'(1);

  always_comb begin
    tick_count_next            = tick_count;
    compare_value_next         = compare_value;
    armed_next                 = armed;
    run_kind_next              = run_kind;
    run_ms_next                = run_ms;
    run_ticks_next             = run_ticks;
    remaining_or_fraction_next = remaining_or_fraction;
    period_frac_next           = period_frac;
    res_fired                  = 1'b0;
    res_fired_ms               = '0;
    res_elapsed                = '0;
    case (stage_mode)
      mscts_pkg::MODE_TICK: begin
        tick_count_next = tick_inc;
        if (armed && tick_inc == compare_value) begin
          if (run_kind == mscts_pkg::KIND_PERIODIC) begin
            res_fired                  = 1'b1;
            res_fired_ms               = run_ms;
            compare_value_next         = compare_value + period_step[CB-1:0];
            remaining_or_fraction_next = RW'(frac_adj);
          end else if (remaining_or_fraction != '0) begin
            // more one-shot ticks to schedule
            compare_value_next         = compare_value + cur_chunk[CB-1:0];
            remaining_or_fraction_next = remaining_or_fraction - cur_chunk[RW-1:0];
          end else begin
            res_fired    = 1'b1;
            res_fired_ms = run_ms;
            run_ms_next  = '0;
            armed_next   = 1'b0;
          end
        end
      end
      mscts_pkg::MODE_PERIODIC: begin
        run_kind_next              = mscts_pkg::KIND_PERIODIC;
        run_ms_next                = stage_ms;
        run_ticks_next             = stage_quot;
        period_frac_next           = stage_frac;
        remaining_or_fraction_next = RW'(stage_frac);
        compare_value_next         = tick_count + CB'(AW'(stage_quot));
        armed_next                 = 1'b1;
      end
      mscts_pkg::MODE_ONCE: begin
        run_kind_next              = mscts_pkg::KIND_ONCE;
        run_ms_next                = stage_ms;
        run_ticks_next             = once_total;
        remaining_or_fraction_next = once_total - once_chunk[RW-1:0];
        compare_value_next         = tick_count + once_chunk[CB-1:0];
        armed_next                 = 1'b1;
      end
      mscts_pkg::MODE_STOP: begin
        armed_next = 1'b0;
      end
      mscts_pkg::MODE_QUERY: begin
        res_elapsed = query_el;
      end
      default: begin
        // unused codes answer zeros
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count            <= '0;
      compare_value         <= '0;
      armed                 <= 1'b0;
      run_kind              <= mscts_pkg::KIND_PERIODIC;
      run_ms                <= '0;
      run_ticks             <= '0;
      remaining_or_fraction <= '0;
      period_frac           <= '0;
    end else if (exec_fire) begin
      tick_count            <= tick_count_next;
      compare_value         <= compare_value_next;
      armed                 <= armed_next;
      run_kind              <= run_kind_next;
      run_ms                <= run_ms_next;
      run_ticks             <= run_ticks_next;
      remaining_or_fraction <= remaining_or_fraction_next;
      period_frac           <= period_frac_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      fired     <= res_fired;
      fired_ms  <= res_fired_ms;
      passed_ms <= res_elapsed;
    end
  end

endmodule

`default_nettype wire

[rtl/core/mscts_checker.sv]
`default_nettype none

module mscts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        fired,
  input wire logic [15:0] fired_ms,
  input wire logic [15:0] passed_ms
);

  // no event, no event interval
  a_quiet_ms: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fired |-> fired_ms == 16'd0)
    else $error("fired_ms nonzero without an event");

  // events come from ticks, elapsed time from queries
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired |-> passed_ms == 16'd0)
    else $error("event and elapsed answer in one word");

  // a stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fired) && $stable(fired_ms)
                              && $stable(passed_ms))
    else $error("stalled result word changed");

endmodule

bind ms_compare_timer_scheduler_core mscts_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .fired     (fired),
  .fired_ms  (fired_ms),
  .passed_ms (passed_ms)
);

`default_nettype wire
